>>> rtl/event_log_ring_with_coalescing_defines.svh
// Assertion macros shared by the event log ring modules.
// Both macros sample on clk and are disabled while rst is high.
`ifndef EVENT_LOG_RING_WITH_COALESCING_DEFINES_SVH
`define EVENT_LOG_RING_WITH_COALESCING_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ELRC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("event log ring: assertion failed");

// Next-cycle implication.
`define ELRC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("event log ring: assertion failed");

`else

`define ELRC_ASSERT_IMP(label, ante, cons)
`define ELRC_ASSERT_NXT(label, ante, cons)

`endif

`endif

>>> rtl/elrc_pkg.sv
package elrc_pkg;

  // Default ring depth.
  localparam int DEFAULT_LOG_DEPTH = 256;

  // Operation codes.
  localparam logic [1:0] OP_LOG   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Action codes with special meaning.
  localparam logic [7:0] ACT_INIT     = 8'd1;
  localparam logic [7:0] ACT_SW       = 8'd4;
  localparam logic [7:0] ACT_SW_MULT  = 8'd5;
  localparam logic [7:0] ACT_LOG      = 8'd9;
  localparam logic [7:0] ACT_LOG_MULT = 8'd10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // input beat taken this cycle
    logic load_read;  // registered memory data is ready for the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;    // the offered beat is a read
  } status_t;

endpackage

>>> rtl/elrc_ctrl.sv
`include "event_log_ring_with_coalescing_defines.svh"

module elrc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  elrc_pkg::status_t status,
  output elrc_pkg::cmd_t    cmd
);

  localparam logic S_IDLE    = 1'b0;
  localparam logic S_RD_WAIT = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;

  // A beat is taken when idle and the result register is free or draining.
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  assign cmd.accept    = accept;
  assign cmd.load_read = (state == S_RD_WAIT);

  // Next state and result valid.
  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.is_read) begin
            state_next = S_RD_WAIT;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_RD_WAIT: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A read waits in S_RD_WAIT for the memory with the result register empty.
  `ELRC_ASSERT_NXT(a_read_waits, accept && status.is_read, state == S_RD_WAIT && !out_valid)
  // The read result appears right after the wait.
  `ELRC_ASSERT_NXT(a_read_done, state == S_RD_WAIT, out_valid && state == S_IDLE)
  // Other beats produce a result on the next cycle.
  `ELRC_ASSERT_NXT(a_other_done, accept && !status.is_read, out_valid)

endmodule

>>> rtl/elrc_datapath.sv
`include "event_log_ring_with_coalescing_defines.svh"

module elrc_datapath #(
  parameter int LOG_DEPTH = elrc_pkg::DEFAULT_LOG_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                log_level_we,
  input  logic [1:0]          log_level,
  input  logic [1:0]          operation,
  input  logic [7:0]          action,
  input  logic [31:0]         source_ip,
  input  logic signed [31:0]  timestamp,
  input  logic [8:0]          read_index,
  input  elrc_pkg::cmd_t      cmd,
  output elrc_pkg::status_t   status,
  output logic signed [31:0]  entry_time,
  output logic [7:0]          entry_action,
  output logic [31:0]         entry_ip,
  output logic [7:0]          write_position,
  output logic                merged
);

  localparam int PTR_W  = $clog2(LOG_DEPTH);
  localparam int WORD_W = 72;

  // Ring state. The written set is every slot below wp, or all of them once wrapped.
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  wp_next;
  logic              wrapped;
  logic              wrapped_next;
  logic [1:0]        level;

  // Copy of the most recently written slot, used for the merge test.
  logic [7:0]        prev_act;
  logic [7:0]        prev_act_next;
  logic [31:0]       prev_ip;
  logic [31:0]       prev_ip_next;
  logic [PTR_W-1:0]  prev_idx;

  // Entry memory: {time, action, address}.
  logic [WORD_W-1:0] mem [LOG_DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              read_hit;
  logic              mem_we;
  logic [PTR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  logic [7:0]        mult_act;
  logic              merge;
  logic              hit_now;

  assign status.is_read = (operation == elrc_pkg::OP_READ);

  assign prev_idx = (wp == '0) ? PTR_W'(LOG_DEPTH - 1) : wp - PTR_W'(1);
  assign mult_act = (action == elrc_pkg::ACT_SW) ? elrc_pkg::ACT_SW_MULT
                                                 : elrc_pkg::ACT_LOG_MULT;

  // Merge when the last written entry repeats the same request from the same address.
  assign merge = (operation == elrc_pkg::OP_LOG) && (level != 2'd0)
              && ((action == elrc_pkg::ACT_SW) || (action == elrc_pkg::ACT_LOG))
              && (wrapped || (wp != '0))
              && ((prev_act == action) || (prev_act == mult_act))
              && (prev_ip == source_ip);

  // A read hits when the index is in range and the slot holds an entry.
  assign hit_now = (32'(read_index) < LOG_DEPTH)
                && (wrapped || (32'(read_index) < 32'(wp)));

  // Ring update and memory write for the accepted beat.
  always_comb begin
    wp_next       = wp;
    wrapped_next  = wrapped;
    prev_act_next = prev_act;
    prev_ip_next  = prev_ip;
    mem_we        = 1'b0;
    mem_waddr     = wp;
    mem_wdata     = {timestamp, action, source_ip};
    if (cmd.accept) begin
      case (operation)
        elrc_pkg::OP_LOG: begin
          if (level != 2'd0) begin
            mem_we = 1'b1;
            if (merge) begin
              mem_waddr     = prev_idx;
              mem_wdata     = {timestamp, mult_act, prev_ip};
              prev_act_next = mult_act;
            end else begin
              prev_act_next = action;
              prev_ip_next  = source_ip;
              if (wp == PTR_W'(LOG_DEPTH - 1)) begin
                wp_next      = '0;
                wrapped_next = 1'b1;
              end else begin
                wp_next = wp + PTR_W'(1);
              end
            end
          end
        end
        elrc_pkg::OP_CLEAR: begin
          mem_we        = 1'b1;
          mem_waddr     = '0;
          mem_wdata     = {timestamp, elrc_pkg::ACT_INIT, 32'd0};
          prev_act_next = elrc_pkg::ACT_INIT;
          prev_ip_next  = 32'd0;
          wp_next       = PTR_W'(1);
          wrapped_next  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      wrapped <= 1'b0;
      level   <= 2'd0;
    end else begin
      wp      <= wp_next;
      wrapped <= wrapped_next;
      if (log_level_we) begin
        level <= log_level;
      end
    end
  end

  // Last-entry copy.
  always_ff @(posedge clk) begin
    prev_act <= prev_act_next;
    prev_ip  <= prev_ip_next;
  end

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[PTR_W'(read_index)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      read_hit <= hit_now;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      entry_time     <= read_hit ? signed'(rd_data[71:40]) : 32'sd0;
      entry_action   <= read_hit ? rd_data[39:32] : 8'd0;
      entry_ip       <= read_hit ? rd_data[31:0] : 32'd0;
      write_position <= 8'(wp);
      merged         <= 1'b0;
    end else if (cmd.accept && !status.is_read) begin
      entry_time     <= 32'sd0;
      entry_action   <= 8'd0;
      entry_ip       <= 32'd0;
      write_position <= 8'(wp_next);
      merged         <= merge;
    end
  end

  // The write pointer stays inside the ring.
  `ELRC_ASSERT_IMP(a_wp_range, 1'b1, 32'(wp) < LOG_DEPTH)
  // A clear leaves one entry at slot zero.
  `ELRC_ASSERT_NXT(a_clear_ptr, cmd.accept && operation == elrc_pkg::OP_CLEAR,
                   wp == PTR_W'(1) && !wrapped)
  // A merge rewrites the previous slot and leaves the pointer alone.
  `ELRC_ASSERT_NXT(a_merge_hold, cmd.accept && merge, wp == $past(wp))

endmodule

>>> rtl/event_log_ring_with_coalescing.sv
// Circular event log of {time, action, source address} entries with coalescing of
// repeated requests. A log beat (operation 0) is ignored while log_level is zero;
// action 4 or 9 from the same address as the last entry (holding 4/5 or 9/10)
// rewrites that entry as 5 or 10 with the new time; any other log beat is
// appended at the write pointer, which wraps at LOG_DEPTH. A read beat
// (operation 1) returns one entry, or zeros for an index at or above LOG_DEPTH or
// a slot not written since the last clear. A clear beat (operation 2) empties the
// ring and records an init entry (action 1, address 0) at slot zero. Every beat
// gives one result beat; write_position is the low eight bits of the pointer
// afterwards. Non-read beats give their result in the next cycle; a read first
// waits on the registered memory read port. A new beat is taken whenever the
// block is not waiting on a read and the result register is empty or being
// drained, so with every result taken the block runs one non-read beat per cycle
// and none while a read waits. The last entry's action and address are registered
// for the merge test and validity follows from the write pointer, so no clearing
// pass is needed after reset or clear. The user writes log_level through
// log_level_we only while idle; the block does not enforce it.
module event_log_ring_with_coalescing #(
  parameter int LOG_DEPTH = elrc_pkg::DEFAULT_LOG_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               log_level_we,
  input  logic [1:0]         log_level,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         action,
  input  logic [31:0]        source_ip,
  input  logic signed [31:0] timestamp,
  input  logic [8:0]         read_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] entry_time,
  output logic [7:0]         entry_action,
  output logic [31:0]        entry_ip,
  output logic [7:0]         write_position,
  output logic               merged
);

  elrc_pkg::cmd_t    cmd;
  elrc_pkg::status_t status;

  // Handshake and sequencing.
  elrc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Ring storage, merge logic and result register.
  elrc_datapath #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .log_level_we   (log_level_we),
    .log_level      (log_level),
    .operation      (operation),
    .action         (action),
    .source_ip      (source_ip),
    .timestamp      (timestamp),
    .read_index     (read_index),
    .cmd            (cmd),
    .status         (status),
    .entry_time     (entry_time),
    .entry_action   (entry_action),
    .entry_ip       (entry_ip),
    .write_position (write_position),
    .merged         (merged)
  );

endmodule

>>> sim/event_log_ring_with_coalescing_checker.sv
module event_log_ring_with_coalescing_checker #(
  parameter int LOG_DEPTH = elrc_pkg::DEFAULT_LOG_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               log_level_we,
  input  logic [1:0]         log_level,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic [7:0]         action,
  input  logic [31:0]        source_ip,
  input  logic signed [31:0] timestamp,
  input  logic [8:0]         read_index,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] entry_time,
  input  logic [7:0]         entry_action,
  input  logic [31:0]        entry_ip,
  input  logic [7:0]         write_position,
  input  logic               merged,
  output int                 mismatch_count,
  output int                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] ent_time;
    logic [7:0]         ent_action;
    logic [31:0]        ent_ip;
    logic [7:0]         wr_pos;
    logic               was_merged;
  } trace_result_t;

  // Shadow copy of the ring, its valid bits, the pointer and the level register.
  logic signed [31:0] slot_time   [LOG_DEPTH];
  logic [7:0]         slot_action [LOG_DEPTH];
  logic [31:0]        slot_ip     [LOG_DEPTH];
  bit                 slot_valid  [LOG_DEPTH];
  int                 wr_ptr;
  logic [1:0]         level_copy;

  trace_result_t awaited_results[$];
  int            results_seen;

  // Writes one entry at the pointer and advances it, wrapping at the ring depth.
  function automatic void append_entry(logic signed [31:0] ts, logic [7:0] act,
                                       logic [31:0] ip);
    slot_time[wr_ptr]   = ts;
    slot_action[wr_ptr] = act;
    slot_ip[wr_ptr]     = ip;
    slot_valid[wr_ptr]  = 1'b1;
    wr_ptr = (wr_ptr == LOG_DEPTH - 1) ? 0 : wr_ptr + 1;
  endfunction

  // Applies one accepted beat to the shadow ring and returns the result it should give.
  function automatic trace_result_t apply_trace_beat(logic [1:0] op, logic [7:0] act,
                                                     logic [31:0] ip, logic signed [31:0] ts,
                                                     logic [8:0] idx);
    trace_result_t r;
    int            prev;
    logic [7:0]    mult;
    bit            hit;
    r    = '0;
    mult = '0;
    hit  = 1'b0;
    case (op)
      elrc_pkg::OP_LOG: begin
        if (level_copy != 2'd0) begin
          // The previous slot wraps to the top of the ring at pointer zero.
          prev = (wr_ptr == 0) ? LOG_DEPTH - 1 : wr_ptr - 1;
          if (act == elrc_pkg::ACT_SW || act == elrc_pkg::ACT_LOG) begin
            mult = (act == elrc_pkg::ACT_SW) ? elrc_pkg::ACT_SW_MULT
                                             : elrc_pkg::ACT_LOG_MULT;
            if (slot_valid[prev])
              hit = (slot_action[prev] == act || slot_action[prev] == mult) &&
                    slot_ip[prev] == ip;
          end
          if (hit) begin
            slot_action[prev] = mult;
            slot_time[prev]   = ts;
            r.was_merged      = 1'b1;
          end else begin
            append_entry(ts, act, ip);
          end
        end
      end
      elrc_pkg::OP_READ: begin
        if (idx < LOG_DEPTH) begin
          if (slot_valid[idx]) begin
            r.ent_time   = slot_time[idx];
            r.ent_action = slot_action[idx];
            r.ent_ip     = slot_ip[idx];
          end
        end
      end
      elrc_pkg::OP_CLEAR: begin
        foreach (slot_valid[i]) slot_valid[i] = 1'b0;
        wr_ptr = 0;
        append_entry(ts, elrc_pkg::ACT_INIT, '0);
      end
      default: ;
    endcase
    r.wr_pos = wr_ptr[7:0];
    return r;
  endfunction

  // Track register writes, predict on each input beat, compare on each result beat.
  always @(posedge clk) begin
    trace_result_t want;
    trace_result_t got;
    if (rst) begin
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      wr_ptr       = 0;
      level_copy   = 2'd0;
      results_seen = 0;
      awaited_results.delete();
      mismatch_count <= 0;
    end else begin
      if (log_level_we)
        level_copy = log_level;
      if (in_valid && in_ready)
        awaited_results.push_back(apply_trace_beat(operation, action, source_ip,
                                                   timestamp, read_index));
      if (out_valid && out_ready) begin
        got = {entry_time, entry_action, entry_ip, write_position, merged};
        if (awaited_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: result beat %0d arrived with nothing expected: t=%h a=%h ip=%h",
                     $realtime, results_seen, got.ent_time, got.ent_action, got.ent_ip);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("%0t: result beat %0d mismatch", $realtime, results_seen);
              $display("  expected t=%h a=%h ip=%h pos=%h merged=%b", want.ent_time,
                       want.ent_action, want.ent_ip, want.wr_pos, want.was_merged);
              $display("  actual   t=%h a=%h ip=%h pos=%h merged=%b", got.ent_time,
                       got.ent_action, got.ent_ip, got.wr_pos, got.was_merged);
            end
            mismatch_count <= mismatch_count + 1;
          end
        end
        results_seen = results_seen + 1;
      end
    end
    pending_count <= awaited_results.size();
  end

endmodule

>>> sim/event_log_ring_with_coalescing_tb.sv
module event_log_ring_with_coalescing_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         LOG_DEPTH   = elrc_pkg::DEFAULT_LOG_DEPTH;
  localparam int         QUIET_LIMIT = 2000;
  localparam logic [1:0] OP_SPARE    = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         act;
    logic [31:0]        ip;
    logic signed [31:0] ts;
    logic [8:0]         idx;
  } beat_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               log_level_we = 1'b0;
  logic [1:0]         log_level    = 2'd0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [1:0]         operation    = elrc_pkg::OP_LOG;
  logic [7:0]         action       = '0;
  logic [31:0]        source_ip    = '0;
  logic signed [31:0] timestamp    = '0;
  logic [8:0]         read_index   = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [31:0] entry_time;
  logic [7:0]         entry_action;
  logic [31:0]        entry_ip;
  logic [7:0]         write_position;
  logic               merged;

  int          mismatch_count;
  int          pending_count;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;
  logic [31:0] last_ip        = '0;

  always #6 clk = ~clk;

  event_log_ring_with_coalescing #(.LOG_DEPTH(LOG_DEPTH)) dut (
    .clk(clk), .rst(rst), .log_level_we(log_level_we), .log_level(log_level),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .action(action),
    .source_ip(source_ip), .timestamp(timestamp), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready), .entry_time(entry_time),
    .entry_action(entry_action), .entry_ip(entry_ip), .write_position(write_position),
    .merged(merged)
  );

  event_log_ring_with_coalescing_checker #(.LOG_DEPTH(LOG_DEPTH)) checker_i (
    .clk(clk), .rst(rst), .log_level_we(log_level_we), .log_level(log_level),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .action(action),
    .source_ip(source_ip), .timestamp(timestamp), .read_index(read_index),
    .out_valid(out_valid), .out_ready(out_ready), .entry_time(entry_time),
    .entry_action(entry_action), .entry_ip(entry_ip), .write_position(write_position),
    .merged(merged), .mismatch_count(mismatch_count), .pending_count(pending_count)
  );

  // The result side stalls at random at the current rate.
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: ends the run when no beat moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic beat_t make_beat(logic [1:0] op, logic [7:0] act, logic [31:0] ip,
                                      logic signed [31:0] ts, logic [8:0] idx);
    beat_t b;
    b = '{op: op, act: act, ip: ip, ts: ts, idx: idx};
    return b;
  endfunction

  // Random beat biased toward repeated requests from the same address, so that
  // merges happen often; the fields an operation ignores are random as well.
  function automatic beat_t random_beat(bit allow_clear);
    beat_t b;
    int    r;
    int    a;
    int    s;
    r = $urandom_range(99);
    if (r < 60)                      b.op = elrc_pkg::OP_LOG;
    else if (r < 88)                 b.op = elrc_pkg::OP_READ;
    else if (r < 91)                 b.op = OP_SPARE;
    else if (allow_clear && r < 94)  b.op = elrc_pkg::OP_CLEAR;
    else                             b.op = elrc_pkg::OP_LOG;
    a = $urandom_range(9);
    if (a < 3)       b.act = elrc_pkg::ACT_SW;
    else if (a < 5)  b.act = elrc_pkg::ACT_LOG;
    else if (a == 5) begin
      s = $urandom_range(2);
      b.act = (s == 0) ? elrc_pkg::ACT_SW_MULT :
              (s == 1) ? elrc_pkg::ACT_LOG_MULT : elrc_pkg::ACT_INIT;
    end else begin
      b.act = 8'($urandom_range(255));
    end
    s = $urandom_range(9);
    if (s < 6)       b.ip = last_ip;
    else if (s < 8)  b.ip = 32'($urandom_range(3));
    else             b.ip = $urandom();
    b.ts  = $urandom();
    b.idx = ($urandom_range(9) < 6) ? 9'($urandom_range(LOG_DEPTH - 1))
                                    : 9'($urandom_range(511));
    if (b.op == elrc_pkg::OP_LOG)
      last_ip = b.ip;
    return b;
  endfunction

  // Offers one beat after a random idle gap and returns at the edge that takes it.
  task automatic send_beat(input beat_t b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    operation  <= b.op;
    action     <= b.act;
    source_ip  <= b.ip;
    timestamp  <= b.ts;
    read_index <= b.idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering beats and waits until every expected result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_log_level(input logic [1:0] value);
    drain_results();
    log_level_we <= 1'b1;
    log_level    <= value;
    @(posedge clk);
    log_level_we <= 1'b0;
  endtask

  task automatic run_phase(input logic [1:0] level, input int idle_pct, input int stall_pct,
                           input int count, input bit allow_clear);
    set_log_level(level);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_beat(random_beat(allow_clear));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: logging disabled after reset, reads of empty slots, spare operation.
    send_beat(make_beat(elrc_pkg::OP_READ, 8'd0, 32'd0, 32'sd0, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_SW, 32'd0, 32'sd7, 9'd0));
    send_beat(make_beat(OP_SPARE, 8'hFF, 32'hFFFF_FFFF, -32'sd1, 9'h1FF));

    // First log after reset: the slot behind pointer zero was never written.
    set_log_level(2'd1);
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_SW, 32'd0, 32'sh7FFF_FFFF, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_SW, 32'd0, 32'sd1, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_LOG, 32'd0, 32'sd2, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_READ, 8'd0, 32'd0, 32'sd0, 9'd0));

    // Clear, then merge chains on both request codes and the cases that break them.
    set_log_level(2'd2);
    send_beat(make_beat(elrc_pkg::OP_CLEAR, 8'hA5, 32'h1234_5678, 32'sh8000_0000, 9'd3));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_SW, 32'd0, 32'sd10, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_SW, 32'd0, -32'sd1, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_SW_MULT, 32'd0, 32'sd12, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_SW, 32'd0, 32'sd13, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_LOG, 32'hDEAD_BEEF, 32'sd14, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_LOG, 32'hDEAD_BEEF, 32'sd15, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_LOG, 32'hDEAD_BEEF, 32'sd16, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, elrc_pkg::ACT_LOG, 32'hDEAD_BEEE, 32'sd17, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_LOG, 8'hFF, 32'hFFFF_FFFF, 32'sd0, 9'd0));
    send_beat(make_beat(elrc_pkg::OP_READ, 8'd0, 32'd0, 32'sd0, 9'd1));
    send_beat(make_beat(elrc_pkg::OP_READ, 8'hFF, 32'hFFFF_FFFF, -32'sd1, 9'd3));
    send_beat(make_beat(elrc_pkg::OP_READ, 8'd0, 32'd0, 32'sd0, 9'd200));
    send_beat(make_beat(elrc_pkg::OP_READ, 8'd0, 32'd0, 32'sd0, 9'd256));
    send_beat(make_beat(elrc_pkg::OP_READ, 8'd0, 32'd0, 32'sd0, 9'h1FF));
    send_beat(make_beat(elrc_pkg::OP_READ, 8'd0, 32'd0, 32'sd0, 9'd0));
    send_beat(make_beat(OP_SPARE, 8'd0, 32'd0, 32'sd0, 9'd0));

    // Random phases; the first two have no clears so the ring wraps.
    run_phase(2'd1, 0, 0, 360, 1'b0);
    run_phase(2'd2, 77, 0, 100, 1'b0);
    run_phase(2'd1, 0, 77, 80, 1'b1);
    run_phase(2'd2, 36, 36, 40, 1'b1);
    run_phase(2'd0, 36, 36, 10, 1'b1);

    drain_results();
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
